// File: src/eab_pkg.sv
// ----------------------------------------------------------------------------
// eab_pkg: shared constants for the Euler angle basis block
// Q30 trig constants, angle folding limits and the degree-to-radian scale.
// ----------------------------------------------------------------------------
package eab_pkg;

   localparam int unsigned FULL_TURN    = 23040;
   localparam int unsigned QUARTER_TURN = 5760;
   localparam int unsigned EIGHTH_TURN  = 2880;

   localparam logic [29:0] RAD_PER_LSB_Q40 = 30'd299845282;
   localparam logic [30:0] Q30_ONE         = 31'h4000_0000;

   // turn count of a magnitude below 2^31: (m * TURN_RECIP) >> TURN_RECIP_SH,
   // low by at most one
   localparam int unsigned TURN_RECIP_SH = 46;
   localparam logic [31:0] TURN_RECIP    =
      32'((64'd1 << TURN_RECIP_SH) / 64'(FULL_TURN));

   // exact floor(n / d) for n < 2^30: (n * RCP_d) >> RSH_d
   localparam int unsigned RSH_72 = 37;
   localparam int unsigned RSH_42 = 36;
   localparam int unsigned RSH_20 = 35;
   localparam int unsigned RSH_6  = 33;
   localparam int unsigned RSH_90 = 37;
   localparam int unsigned RSH_56 = 36;
   localparam int unsigned RSH_30 = 35;
   localparam int unsigned RSH_12 = 34;
   localparam logic [30:0] RCP_72 = 31'(((64'd1 << RSH_72) + 64'd71) / 64'd72);
   localparam logic [30:0] RCP_42 = 31'(((64'd1 << RSH_42) + 64'd41) / 64'd42);
   localparam logic [30:0] RCP_20 = 31'(((64'd1 << RSH_20) + 64'd19) / 64'd20);
   localparam logic [30:0] RCP_6  = 31'(((64'd1 << RSH_6) + 64'd5) / 64'd6);
   localparam logic [30:0] RCP_90 = 31'(((64'd1 << RSH_90) + 64'd89) / 64'd90);
   localparam logic [30:0] RCP_56 = 31'(((64'd1 << RSH_56) + 64'd55) / 64'd56);
   localparam logic [30:0] RCP_30 = 31'(((64'd1 << RSH_30) + 64'd29) / 64'd30);
   localparam logic [30:0] RCP_12 = 31'(((64'd1 << RSH_12) + 64'd11) / 64'd12);

   // trig pair in signed Q30 (magnitude at most 2^30)
   typedef struct packed {
      logic signed [31:0] s;
      logic signed [31:0] c;
   } trig_type;

endpackage

// File: src/euler_angles_to_basis.sv
// ----------------------------------------------------------------------------
// euler_angles_to_basis: Euler angles to forward/right/up basis vectors
// Three angles, LSB 1/64 degree, in; nine Q1.OUT_FRAC_BITS components out.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata fields (lowest bit first)           | tdata bits
//  --------+-----+-------------------------------------------+-----------
//  req_    | in  | yaw_angle, pitch_angle, roll_angle         | 48
//  rsp_    | out | forward xyz, right xyz, up xyz             | 144
//
//  One item per cycle while rsp_ does not stall, fully pipelined through LAT
//  stages (magnitude, turn count, remainder, wrap, fold, radians, x^2, four
//  series steps of two stages each, sin/cos select, pair products, triple
//  products, sum, round/saturate), one Q30 multiply deep per stage.
//  Reset is synchronous and clears only the stage valid bits.
//  A stall on rsp_ freezes every stage at once (global enable); req_tready is
//  high whenever the output stage is empty or being taken.
//
module euler_angles_to_basis #(
   parameter int ANGLE_BITS    = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // yaw_angle, pitch_angle, roll_angle
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata   // forward_x,y,z, right_x,y,z, up_x,y,z
);
   import eab_pkg::*;

   // stages: 0 magnitude, 1 turn count, 2 remainder, 3 wrap into [0,360),
   // 4 quadrant/fold, 5 radians, 6 x^2, 7..13 series (divide, multiply),
   // 14 last series multiply, 15 sin/cos select, 16 pair products,
   // 17 triple products, 18 sums, 19 round/saturate (output)
   localparam int LAT = 20;
   localparam int SH  = 60 - OUT_FRAC_BITS;
   localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

   logic [LAT-1:0] vld_ff;
   logic           adv;

   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // ------------------------------------------------------------ per-angle trig
   function automatic logic [30:0] umul30(input logic [30:0] a, input logic [30:0] b);
      logic [61:0] p;
      p = 62'(a) * 62'(b) + 62'(1 << 29);
      return p[60:30];
   endfunction

   // floor(n / d) by reciprocal multiply, m and sh from the package
   function automatic logic [29:0] div_rcp(input logic [29:0] n, input logic [30:0] m,
                                           input int unsigned sh);
      logic [60:0] p;
      p = 61'(n) * 61'(m);
      return 30'(p >> sh);
   endfunction

   trig_type trig_w [3];   // lanes 0..2 = yaw, pitch, roll (stage 15)

   for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [ANGLE_BITS-1:0] v_w;
      logic [31:0] mg_w;
      logic [63:0] qp_w;
      logic [16:0] rd_w;
      logic [1:0]  qq_w;
      logic [14:0] fq_w;
      logic [43:0] xp_w;
      logic [30:0] c_w, ss_w, cc_w;

      logic        neg_ff [3];    // stages 0..2
      logic [31:0] mag_ff [2];    // stages 0..1
      logic [16:0] qe_ff;         // stage 1
      logic [16:0] rem_ff;        // stage 2, 0..46079
      logic [14:0] r_ff;          // stage 3, 0..23039
      logic [1:0]  q_ff  [11];    // stages 4..14
      logic        sw_ff [11];
      logic [11:0] f_ff;          // stage 4, 0..2880
      logic [30:0] x_ff  [9];     // stages 5..13, radians Q30
      logic [30:0] x2_ff [8];     // stages 6..13
      logic [30:0] ts_ff [4];     // stages 7, 9, 11, 13
      logic [30:0] tc_ff [4];
      logic [30:0] ms_ff [3];     // stages 8, 10, 12
      logic [30:0] mc_ff [3];
      logic [30:0] s_ff, mn_ff;   // stage 14
      trig_type    tr_ff;         // stage 15

      // field cut to its low ANGLE_BITS bits, the top one taken as the sign
      assign v_w  = ANGLE_BITS'(32'(req_tdata[16*k +: 16]));
      assign mg_w = v_w[ANGLE_BITS-1] ? (32'd0 - 32'(v_w)) & ANGLE_MASK : 32'(v_w);
      assign qp_w = 64'(mag_ff[0]) * 64'(TURN_RECIP);
      assign rd_w = (rem_ff >= 17'(FULL_TURN)) ? rem_ff - 17'(FULL_TURN) : rem_ff;
      assign qq_w = (r_ff >= 15'(3 * QUARTER_TURN)) ? 2'd3 :
                    (r_ff >= 15'(2 * QUARTER_TURN)) ? 2'd2 :
                    (r_ff >= 15'(QUARTER_TURN))     ? 2'd1 : 2'd0;
      assign fq_w = r_ff - 15'(qq_w) * 15'(QUARTER_TURN);
      assign xp_w = 44'(f_ff) * 44'(RAD_PER_LSB_Q40) + 44'd512;
      assign c_w  = Q30_ONE - (mn_ff >> 1);
      assign ss_w = sw_ff[10] ? c_w : s_ff;
      assign cc_w = sw_ff[10] ? s_ff : c_w;
      assign trig_w[k] = tr_ff;

      always_ff @(posedge clock) begin
         if (adv) begin
            neg_ff[0] <= v_w[ANGLE_BITS-1];
            mag_ff[0] <= mg_w;
            neg_ff[1] <= neg_ff[0];
            mag_ff[1] <= mag_ff[0];
            qe_ff     <= 17'(qp_w >> TURN_RECIP_SH);
            neg_ff[2] <= neg_ff[1];
            rem_ff    <= 17'(mag_ff[1] - 32'(qe_ff) * 32'(FULL_TURN));
            // negative angle: remainder counts back from a full turn
            r_ff <= 15'((neg_ff[2] && rd_w != 17'd0) ? 17'(FULL_TURN) - rd_w : rd_w);
            q_ff[0]  <= qq_w;
            sw_ff[0] <= fq_w > 15'(EIGHTH_TURN);
            f_ff <= 12'(fq_w > 15'(EIGHTH_TURN) ? 15'(QUARTER_TURN) - fq_w : fq_w);
            x_ff[0]  <= xp_w[40:10];
            x2_ff[0] <= umul30(x_ff[0], x_ff[0]);
            for (int i = 1; i < 11; i++) begin
               q_ff[i]  <= q_ff[i-1];
               sw_ff[i] <= sw_ff[i-1];
            end
            for (int i = 1; i < 9; i++) x_ff[i] <= x_ff[i-1];
            for (int i = 1; i < 8; i++) x2_ff[i] <= x2_ff[i-1];
            // series: sin divisors 72,42,20,6; cos 90,56,30,12 then /2
            ts_ff[0] <= Q30_ONE - 31'(div_rcp(x2_ff[0][29:0], RCP_72, RSH_72));
            tc_ff[0] <= Q30_ONE - 31'(div_rcp(x2_ff[0][29:0], RCP_90, RSH_90));
            ms_ff[0] <= umul30(x2_ff[1], ts_ff[0]);
            mc_ff[0] <= umul30(x2_ff[1], tc_ff[0]);
            ts_ff[1] <= Q30_ONE - 31'(div_rcp(ms_ff[0][29:0], RCP_42, RSH_42));
            tc_ff[1] <= Q30_ONE - 31'(div_rcp(mc_ff[0][29:0], RCP_56, RSH_56));
            ms_ff[1] <= umul30(x2_ff[3], ts_ff[1]);
            mc_ff[1] <= umul30(x2_ff[3], tc_ff[1]);
            ts_ff[2] <= Q30_ONE - 31'(div_rcp(ms_ff[1][29:0], RCP_20, RSH_20));
            tc_ff[2] <= Q30_ONE - 31'(div_rcp(mc_ff[1][29:0], RCP_30, RSH_30));
            ms_ff[2] <= umul30(x2_ff[5], ts_ff[2]);
            mc_ff[2] <= umul30(x2_ff[5], tc_ff[2]);
            ts_ff[3] <= Q30_ONE - 31'(div_rcp(ms_ff[2][29:0], RCP_6, RSH_6));
            tc_ff[3] <= Q30_ONE - 31'(div_rcp(mc_ff[2][29:0], RCP_12, RSH_12));
            s_ff  <= umul30(x_ff[8], ts_ff[3]);
            mn_ff <= umul30(x2_ff[7], tc_ff[3]);
            case (q_ff[10])
               2'd1: begin
                  tr_ff.s <= $signed({1'b0, cc_w});
                  tr_ff.c <= -$signed({1'b0, ss_w});
               end
               2'd2: begin
                  tr_ff.s <= -$signed({1'b0, ss_w});
                  tr_ff.c <= -$signed({1'b0, cc_w});
               end
               2'd3: begin
                  tr_ff.s <= -$signed({1'b0, cc_w});
                  tr_ff.c <= $signed({1'b0, ss_w});
               end
               default: begin
                  tr_ff.s <= $signed({1'b0, ss_w});
                  tr_ff.c <= $signed({1'b0, cc_w});
               end
            endcase
         end
      end
   end

   // ------------------------------------------------------------ products
   logic signed [31:0] yrsps_ff, yrcps_ff;
   trig_type           y1_ff, p1_ff, r1_ff;
   logic signed [63:0] pr_ff [13];
   logic signed [63:0] sm_ff [9];
   logic [15:0]        o_ff  [9];

   function automatic logic signed [31:0] smul30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic [30:0] ma, mb, m;
      ma = 31'(a < 0 ? -a : a);
      mb = 31'(b < 0 ? -b : b);
      m  = umul30(ma, mb);
      return ((a < 0) != (b < 0)) ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   function automatic logic [15:0] outq(input logic signed [63:0] v);
      logic [63:0] m;
      m = 64'(v < 0 ? -v : v);
      m = (m + (64'd1 << (SH - 1))) >> SH;
      if (m > (64'd1 << OUT_FRAC_BITS)) m = 64'd1 << OUT_FRAC_BITS;
      return 16'(v < 0 ? -m : m);
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         yrsps_ff <= smul30(trig_w[2].s, trig_w[1].s);
         yrcps_ff <= smul30(trig_w[2].c, trig_w[1].s);
         y1_ff <= trig_w[0];
         p1_ff <= trig_w[1];
         r1_ff <= trig_w[2];
         pr_ff[0]  <= p1_ff.c * y1_ff.c;
         pr_ff[1]  <= p1_ff.c * y1_ff.s;
         pr_ff[2]  <= -(64'(p1_ff.s) <<< 30);
         pr_ff[3]  <= -(yrsps_ff * y1_ff.c);
         pr_ff[4]  <= r1_ff.c * y1_ff.s;
         pr_ff[5]  <= -(yrsps_ff * y1_ff.s);
         pr_ff[6]  <= r1_ff.c * y1_ff.c;
         pr_ff[7]  <= -(r1_ff.s * p1_ff.c);
         pr_ff[8]  <= yrcps_ff * y1_ff.c;
         pr_ff[9]  <= r1_ff.s * y1_ff.s;
         pr_ff[10] <= yrcps_ff * y1_ff.s;
         pr_ff[11] <= r1_ff.s * y1_ff.c;
         pr_ff[12] <= r1_ff.c * p1_ff.c;
         sm_ff[0] <= pr_ff[0];
         sm_ff[1] <= pr_ff[1];
         sm_ff[2] <= pr_ff[2];
         sm_ff[3] <= pr_ff[3] + pr_ff[4];
         sm_ff[4] <= pr_ff[5] - pr_ff[6];
         sm_ff[5] <= pr_ff[7];
         sm_ff[6] <= pr_ff[8] + pr_ff[9];
         sm_ff[7] <= pr_ff[10] - pr_ff[11];
         sm_ff[8] <= pr_ff[12];
         for (int i = 0; i < 9; i++) o_ff[i] <= outq(sm_ff[i]);
      end
   end

   for (genvar i = 0; i < 9; i++) begin : g_out
      assign rsp_tdata[16*i +: 16] = o_ff[i];
   end

`ifndef NO_ASSERTIONS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output changed under stall");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipeline blocked while output empty");
`endif

endmodule

// File: tb/euler_angles_to_basis_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_angles_to_basis_tb: self-checking bench for the Euler angle basis block
// Drives angle triples over req_, predicts the nine Q1.14 basis components
// with a bit-exact fixed-point model, and checks each rsp_ item in order.
// ----------------------------------------------------------------------------
module euler_angles_to_basis_tb;
   import eab_pkg::*;

   localparam int ANGLE_BITS    = 16;
   localparam int OUT_FRAC_BITS = 14;
   localparam int WATCHDOG_MAX  = 20000;
   localparam int DRAIN_CYCLES  = 64;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;   // yaw_angle, pitch_angle, roll_angle
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;       // forward_x,y,z, right_x,y,z, up_x,y,z

   euler_angles_to_basis #(
      .ANGLE_BITS   (ANGLE_BITS),
      .OUT_FRAC_BITS(OUT_FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [47:0]  angle_queue[$];   // items waiting to be sent
   logic [143:0] basis_queue[$];   // predicted results in order
   int           mismatches = 0;
   int           idle_cycles = 0;
   bit           calm = 1'b0;       // no idling on either side while set
   bit           hold_off = 1'b0;   // sender paused until results drain

   // ---- predictor ---------------------------------------------------------
   // Unsigned Q30 multiply with round-half-up.
   function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
      return (a * b + 64'd536870912) >> 30;
   endfunction

   // Signed Q30 multiply: magnitude rounded, sign reapplied.
   function automatic longint smul_q30(longint a, longint b);
      logic [63:0] m;
      m = mul_q30(a < 0 ? -a : a, b < 0 ? -b : b);
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   // Sine and cosine of one raw angle, each signed Q30.
   function automatic trig_type angle_sin_cos(logic [15:0] raw);
      trig_type    tc;
      longint      a, r, q, f;
      bit          swap;
      logic [63:0] x, x2, t, s, c;
      longint      ss, cc;
      a = longint'($signed(raw[ANGLE_BITS-1:0]));
      r = a % longint'(FULL_TURN);
      if (r < 0) r += longint'(FULL_TURN);
      q = r / QUARTER_TURN;
      f = r % QUARTER_TURN;
      swap = 1'b0;
      if (f > EIGHTH_TURN) begin
         f = QUARTER_TURN - f;
         swap = 1'b1;
      end
      x  = (64'(f) * 64'(RAD_PER_LSB_Q40) + 64'd512) >> 10;
      x2 = mul_q30(x, x);
      t = 64'(Q30_ONE) - x2 / 72;
      t = 64'(Q30_ONE) - mul_q30(x2, t) / 42;
      t = 64'(Q30_ONE) - mul_q30(x2, t) / 20;
      t = 64'(Q30_ONE) - mul_q30(x2, t) / 6;
      s = mul_q30(x, t);
      t = 64'(Q30_ONE) - x2 / 90;
      t = 64'(Q30_ONE) - mul_q30(x2, t) / 56;
      t = 64'(Q30_ONE) - mul_q30(x2, t) / 30;
      t = 64'(Q30_ONE) - mul_q30(x2, t) / 12;
      c = 64'(Q30_ONE) - mul_q30(x2, t) / 2;
      ss = swap ? longint'(c) : longint'(s);
      cc = swap ? longint'(s) : longint'(c);
      case (q)
         1:       begin tc.s = 32'(cc);  tc.c = 32'(-ss); end
         2:       begin tc.s = 32'(-ss); tc.c = 32'(-cc); end
         3:       begin tc.s = 32'(-cc); tc.c = 32'(ss);  end
         default: begin tc.s = 32'(ss);  tc.c = 32'(cc);  end
      endcase
      return tc;
   endfunction

   // Q60 to output field: round half away, saturate to 1.0, keep 16 bits.
   function automatic logic [15:0] q60_to_field(longint v);
      int unsigned sh;
      logic [63:0] m;
      sh = 60 - OUT_FRAC_BITS;
      m = v < 0 ? -v : v;
      m = (m + (64'd1 << (sh - 1))) >> sh;
      if (m > (64'd1 << OUT_FRAC_BITS)) m = 64'd1 << OUT_FRAC_BITS;
      return v < 0 ? 16'(-m) : 16'(m);
   endfunction

   function automatic logic [143:0] predict_basis(logic [47:0] angles);
      trig_type yw, pt, rl;
      longint   ys, yc, ps, pc, rs, rc, rsps, rcps;
      logic [143:0] b;
      yw = angle_sin_cos(angles[15:0]);
      pt = angle_sin_cos(angles[31:16]);
      rl = angle_sin_cos(angles[47:32]);
      ys = yw.s; yc = yw.c; ps = pt.s; pc = pt.c; rs = rl.s; rc = rl.c;
      rsps = smul_q30(rs, ps);
      rcps = smul_q30(rc, ps);
      b[15:0]    = q60_to_field(pc * yc);
      b[31:16]   = q60_to_field(pc * ys);
      b[47:32]   = q60_to_field(-ps * (longint'(1) << 30));
      b[63:48]   = q60_to_field(-rsps * yc + rc * ys);
      b[79:64]   = q60_to_field(-rsps * ys - rc * yc);
      b[95:80]   = q60_to_field(-rs * pc);
      b[111:96]  = q60_to_field(rcps * yc + rs * ys);
      b[127:112] = q60_to_field(rcps * ys - rs * yc);
      b[143:128] = q60_to_field(rc * pc);
      return b;
   endfunction

   // ---- driver --------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         // previous item (if any) taken; offer the next one or idle
         if (req_tvalid) basis_queue.push_back(predict_basis(req_tdata));
         if (angle_queue.size() != 0 && !hold_off &&
             (calm || $urandom_range(99) >= 22)) begin
            req_tdata  <= angle_queue.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---- monitor and checker ---------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (basis_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
            end else begin
               logic [143:0] want;
               want = basis_queue.pop_front();
               for (int k = 0; k < 9; k++)
                  if (want[k*16 +: 16] !== rsp_tdata[k*16 +: 16]) begin
                     mismatches++;
                     if (mismatches <= 10)
                        $display("field %0d: expected %h got %h", k,
                                 want[k*16 +: 16], rsp_tdata[k*16 +: 16]);
                  end
            end
         end
         rsp_tready <= calm || $urandom_range(99) >= 22;
      end
   end

   // ---- watchdog: cycles with no item accepted on either side ----------------
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("FAIL euler_angles_to_basis");
         $finish;
      end
   end

   function automatic logic [47:0] pack_angles(int y, int p, int r);
      return {16'(r), 16'(p), 16'(y)};
   endfunction

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(5))
         0:       return 16'($urandom_range(8) * 2880 + $urandom_range(2) - 1);
         1:       return -16'($urandom_range(8) * 2880);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int d[16];
      d = '{0, 1, -1, 32767, -32768, 2880, 2881, 5760, 11520, 17280,
            23040, -23040, -5760, 8640, 2879, 46};
      // directed: extremes, octant and quadrant edges, negatives, full turns
      for (int k = 0; k < 16; k++)
         angle_queue.push_back(pack_angles(d[k], d[(k + 5) % 16], d[(k + 11) % 16]));
      angle_queue.push_back(pack_angles(32767, 32767, 32767));
      angle_queue.push_back(pack_angles(-32768, -32768, -32768));
      angle_queue.push_back(pack_angles(5760, 5760, 5760));      // gimbal lock
      angle_queue.push_back(pack_angles(2880, -5760, 11520));
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < 900; k++) begin
         angle_queue.push_back({rand_angle(), rand_angle(), rand_angle()});
         if (k == 300) begin
            // let everything drain before sending more
            wait (angle_queue.size() == 0);
            @(posedge clock);
            hold_off <= 1'b1;
            wait (basis_queue.size() == 0 && !req_tvalid);
            @(posedge clock);
            hold_off <= 1'b0;
         end
         if (k == 500) begin
            // items 501..650 go out with no idling on either side
            wait (angle_queue.size() == 0);
            calm <= 1'b1;
         end
         if (k == 650) begin
            wait (angle_queue.size() == 0);
            calm <= 1'b0;
         end
      end

      wait (angle_queue.size() == 0);
      wait (!req_tvalid);
      wait (basis_queue.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && basis_queue.size() == 0)
         $display("PASS euler_angles_to_basis");
      else
         $display("FAIL euler_angles_to_basis");
      $finish;
   end

endmodule
